>>> sv/slci_pkg.sv
// ----------------------------------------------------------------------------
// slci_pkg: shared types and constants of the serial line command interpreter
// Item kinds, queue entry, message codes, command texts and character codes.
// ----------------------------------------------------------------------------
package slci_pkg;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_DEL = 8'h7F;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_ERASE,
    KIND_EOL,
    KIND_CHAR
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [2:0] {
    MSG_PROMPT,
    MSG_ERASE,
    MSG_ECHO,
    MSG_CRLF,
    MSG_CRLF_PROMPT,
    MSG_UNKNOWN
  } msg_t;

  localparam int MSG_IDX_W = 5;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_EXEC,
    B_EMIT
  } bstate_t;

  typedef logic [2:0] led_t;

  localparam int NUM_CMD   = 9;
  localparam int CMD_MAX   = 14;
  localparam int CMD_IDX_W = 4;
  localparam int CMD_EXIT  = 0;

  typedef logic [NUM_CMD-1:0] cmd_mask_t;

  localparam logic [CMD_MAX*8-1:0] CMD_TEXT [NUM_CMD] = '{
    "exit",
    "turn on red",
    "turn on blue",
    "turn on green",
    "turn off red",
    "turn off blue",
    "turn off green",
    "turn on all",
    "turn off all"
  };

  localparam logic [CMD_IDX_W-1:0] CMD_LEN [NUM_CMD] = '{
    4'd4, 4'd11, 4'd12, 4'd13, 4'd12, 4'd13, 4'd14, 4'd11, 4'd12
  };

  // bit 0 red, bit 1 green, bit 2 blue
  localparam led_t CMD_SET [NUM_CMD] = '{
    3'b000, 3'b001, 3'b100, 3'b010, 3'b000, 3'b000, 3'b000, 3'b111, 3'b000
  };

  localparam led_t CMD_CLR [NUM_CMD] = '{
    3'b000, 3'b000, 3'b000, 3'b000, 3'b001, 3'b100, 3'b010, 3'b000, 3'b111
  };

  localparam int UNK_LEN = 21;

  localparam logic [15:0]          PROMPT_TEXT      = {CH_GT, CH_SP};
  localparam logic [23:0]          ERASE_TEXT       = {CH_BS, CH_SP, CH_BS};
  localparam logic [15:0]          CRLF_TEXT        = {CH_CR, CH_LF};
  localparam logic [31:0]          CRLF_PROMPT_TEXT = {CH_CR, CH_LF, CH_GT, CH_SP};
  localparam logic [UNK_LEN*8-1:0] UNK_TEXT         =
    {CH_CR, CH_LF, "unknown command", CH_CR, CH_LF, CH_GT, CH_SP};

  function automatic logic [7:0] cmd_char(int c, logic [CMD_IDX_W-1:0] idx);
    int         pos;
    logic [7:0] ch;
    pos = int'(CMD_LEN[c]) - 1 - int'(idx);
    ch  = 8'h00;
    if (pos >= 0) begin
      ch = CMD_TEXT[c][pos*8 +: 8];
    end
    return ch;
  endfunction

  function automatic logic [MSG_IDX_W-1:0] msg_len(msg_t m);
    logic [MSG_IDX_W-1:0] n;
    unique case (m)
      MSG_PROMPT:      n = MSG_IDX_W'(2);
      MSG_ERASE:       n = MSG_IDX_W'(3);
      MSG_ECHO:        n = MSG_IDX_W'(1);
      MSG_CRLF:        n = MSG_IDX_W'(2);
      MSG_CRLF_PROMPT: n = MSG_IDX_W'(4);
      MSG_UNKNOWN:     n = MSG_IDX_W'(UNK_LEN);
      default:         n = MSG_IDX_W'(1);
    endcase
    return n;
  endfunction

  function automatic logic [7:0] msg_char(msg_t m, logic [MSG_IDX_W-1:0] idx,
                                          logic [7:0] echo);
    int         rev;
    logic [7:0] ch;
    rev = int'(msg_len(m)) - 1 - int'(idx);
    if (rev < 0) begin
      rev = 0;
    end
    unique case (m)
      MSG_PROMPT:      ch = PROMPT_TEXT[rev*8 +: 8];
      MSG_ERASE:       ch = ERASE_TEXT[rev*8 +: 8];
      MSG_CRLF:        ch = CRLF_TEXT[rev*8 +: 8];
      MSG_CRLF_PROMPT: ch = CRLF_PROMPT_TEXT[rev*8 +: 8];
      MSG_UNKNOWN:     ch = UNK_TEXT[rev*8 +: 8];
      default:         ch = echo;
    endcase
    return ch;
  endfunction

endpackage

>>> sv/slci_if.sv
// ----------------------------------------------------------------------------
// slci_in_if / slci_out_if: item channels of the command interpreter
// Valid/ready channels carrying received bytes in and transmit bytes out.
// ----------------------------------------------------------------------------
interface slci_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface slci_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       red_on;
  logic       green_on;
  logic       blue_on;
  logic       exited;
  logic       last;

  modport source (output valid, tx_byte, red_on, green_on, blue_on, exited, last,
                  input ready);
  modport sink   (input valid, tx_byte, red_on, green_on, blue_on, exited, last,
                  output ready);
endinterface

>>> sv/slci_front.sv
// ----------------------------------------------------------------------------
// slci_front: input classifier
// Sorts each received item into start, erase, line end or plain character.
// ----------------------------------------------------------------------------
module slci_front (
  slci_in_if.sink        in_ch,
  output slci_pkg::item_t push_item,
  output logic           push_valid,
  input  logic           push_ready
);
  import slci_pkg::*;

  assign push_valid   = in_ch.valid;
  assign in_ch.ready  = push_ready;

  always_comb begin
    push_item.data = in_ch.rx_byte;
    priority if (!in_ch.action) begin
      push_item.kind = KIND_START;
    end else if (in_ch.rx_byte == CH_BS || in_ch.rx_byte == CH_DEL) begin
      push_item.kind = KIND_ERASE;
    end else if (in_ch.rx_byte == CH_CR || in_ch.rx_byte == CH_LF) begin
      push_item.kind = KIND_EOL;
    end else begin
      push_item.kind = KIND_CHAR;
    end
  end

endmodule

>>> sv/slci_fifo.sv
// ----------------------------------------------------------------------------
// slci_fifo: item queue
// Short register queue between the classifier and the line engine.
// ----------------------------------------------------------------------------
module slci_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  slci_pkg::item_t push_item,
  input  logic            push_valid,
  output logic            push_ready,
  output slci_pkg::item_t pop_item,
  output logic            pop_valid,
  input  logic            pop_ready
);
  import slci_pkg::*;

  item_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> sv/slci_back.sv
// ----------------------------------------------------------------------------
// slci_back: line engine
// Keeps the line store, matches commands character by character, drives the
// LED levels and sends echo and message bytes through an output register.
// ----------------------------------------------------------------------------
module slci_back #(
  parameter int LINE_BYTES = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  slci_pkg::item_t pop_item,
  input  logic            pop_valid,
  output logic            pop_ready,
  slci_out_if.source      out_ch
);
  import slci_pkg::*;

  localparam int DEPTH  = LINE_BYTES - 1;
  localparam int LEN_W  = $clog2(LINE_BYTES);
  localparam int ADDR_W = $clog2(DEPTH);

  bstate_t              state_r, state_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  led_t                 led_r, led_nxt;
  logic                 halted_r, halted_nxt;
  cmd_mask_t            mask_r, mask_nxt;
  logic [CMD_IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  msg_t                 msg_r, msg_nxt;
  logic [MSG_IDX_W-1:0] emit_idx_r, emit_idx_nxt;
  logic [7:0]           echo_r, echo_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           tx_r, tx_nxt;
  led_t                 led_out_r, led_out_nxt;
  logic                 exited_r, exited_nxt;
  logic                 last_r, last_nxt;

  logic [7:0]           line_mem_r [DEPTH];
  logic [7:0]           rd_data_r;
  logic                 mem_we;

  logic                 take, line_full, out_free, emit_last, scan_done;
  cmd_mask_t            mask_init, mask_cmp;
  led_t                 led_apply;

  assign take      = pop_valid && (state_r == B_IDLE);
  assign line_full = (len_r == LEN_W'(DEPTH));
  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit_last = (emit_idx_r == msg_len(msg_r) - MSG_IDX_W'(1));
  assign scan_done = ((LEN_W'(scan_idx_r) + LEN_W'(1)) == len_r);

  always_comb begin
    led_apply = led_r;
    for (int c = 0; c < NUM_CMD; c++) begin
      mask_init[c] = (len_r == LEN_W'(CMD_LEN[c]));
      mask_cmp[c]  = mask_r[c] && (rd_data_r == cmd_char(c, scan_idx_r));
      if (mask_r[c]) begin
        led_apply = (led_apply & ~CMD_CLR[c]) | CMD_SET[c];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          unique case (pop_item.kind)
            KIND_START: state_nxt = B_EMIT;
            KIND_ERASE: if (!halted_r && len_r != '0) state_nxt = B_EMIT;
            KIND_CHAR:  if (!halted_r && !line_full) state_nxt = B_EMIT;
            KIND_EOL: begin
              if (!halted_r) begin
                priority if (len_r == '0) begin
                  state_nxt = B_EMIT;
                end else if (mask_init == '0) begin
                  state_nxt = B_EXEC;
                end else begin
                  state_nxt = B_READ;
                end
              end
            end
            default: state_nxt = B_IDLE;
          endcase
        end
      end
      B_READ: state_nxt = B_CMP;
      B_CMP:  state_nxt = scan_done ? B_EXEC : B_READ;
      B_EXEC: state_nxt = B_EMIT;
      B_EMIT: if (out_free && emit_last) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    len_nxt       = len_r;
    led_nxt       = led_r;
    halted_nxt    = halted_r;
    mask_nxt      = mask_r;
    scan_idx_nxt  = scan_idx_r;
    msg_nxt       = msg_r;
    emit_idx_nxt  = emit_idx_r;
    echo_nxt      = echo_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    tx_nxt        = tx_r;
    led_out_nxt   = led_out_r;
    exited_nxt    = exited_r;
    last_nxt      = last_r;
    mem_we        = 1'b0;
    pop_ready     = (state_r == B_IDLE);

    unique case (state_r)
      B_IDLE: begin
        emit_idx_nxt = '0;
        scan_idx_nxt = '0;
        if (take) begin
          unique case (pop_item.kind)
            KIND_START: begin
              halted_nxt = 1'b0;
              len_nxt    = '0;
              msg_nxt    = MSG_PROMPT;
            end
            KIND_ERASE: begin
              if (!halted_r && len_r != '0) begin
                len_nxt = len_r - LEN_W'(1);
                msg_nxt = MSG_ERASE;
              end
            end
            KIND_CHAR: begin
              if (!halted_r && !line_full) begin
                mem_we   = 1'b1;
                len_nxt  = len_r + LEN_W'(1);
                echo_nxt = pop_item.data;
                msg_nxt  = MSG_ECHO;
              end
            end
            KIND_EOL: begin
              msg_nxt  = MSG_CRLF_PROMPT;
              mask_nxt = mask_init;
            end
            default: msg_nxt = msg_r;
          endcase
        end
      end
      B_CMP: begin
        mask_nxt = mask_cmp;
        if (!scan_done) begin
          scan_idx_nxt = scan_idx_r + CMD_IDX_W'(1);
        end
      end
      B_EXEC: begin
        len_nxt = '0;
        priority if (mask_r[CMD_EXIT]) begin
          halted_nxt = 1'b1;
          msg_nxt    = MSG_CRLF;
        end else if (mask_r != '0) begin
          led_nxt = led_apply;
          msg_nxt = MSG_CRLF_PROMPT;
        end else begin
          msg_nxt = MSG_UNKNOWN;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          tx_nxt        = msg_char(msg_r, emit_idx_r, echo_r);
          led_out_nxt   = led_r;
          exited_nxt    = halted_r;
          last_nxt      = emit_last;
          emit_idx_nxt  = emit_idx_r + MSG_IDX_W'(1);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      len_r       <= '0;
      led_r       <= '0;
      halted_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      led_r       <= led_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r     <= mask_nxt;
    scan_idx_r <= scan_idx_nxt;
    msg_r      <= msg_nxt;
    emit_idx_r <= emit_idx_nxt;
    echo_r     <= echo_nxt;
    tx_r       <= tx_nxt;
    led_out_r  <= led_out_nxt;
    exited_r   <= exited_nxt;
    last_r     <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem_r[len_r[ADDR_W-1:0]] <= pop_item.data;
    end
    rd_data_r <= line_mem_r[ADDR_W'(scan_idx_r)];
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tx_byte  = tx_r;
  assign out_ch.red_on   = led_out_r[0];
  assign out_ch.green_on = led_out_r[1];
  assign out_ch.blue_on  = led_out_r[2];
  assign out_ch.exited   = exited_r;
  assign out_ch.last     = last_r;

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(DEPTH))
    else $error("line length beyond store depth");

  a_exec_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EXEC |=> len_r == '0)
    else $error("line not cleared after line end");

  a_scan_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_READ || state_r == B_CMP) |->
      (!halted_r && scan_idx_r < CMD_IDX_W'(CMD_MAX)))
    else $error("command scan out of range or while halted");

  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT |-> emit_idx_r < msg_len(msg_r))
    else $error("message index beyond message length");
`endif

endmodule

>>> sv/serial_line_command_interpreter.sv
// ----------------------------------------------------------------------------
// serial_line_command_interpreter: editable command line over a serial link
// Echoes and edits received bytes, interprets LED and exit commands on line
// end, and answers with prompt or error text.
// ----------------------------------------------------------------------------
// Each received item is classified and queued (two entries), then handled by
// the line engine, which sends one transmit byte per cycle while the receiver
// is ready, through an output register. An ordinary character or erase is
// taken and then echoed; a line end reads and compares each stored character
// in turn (only for lines whose length equals that of some command, so at most
// 14 characters, none otherwise), then decides, then sends the reply, up to
// 21 bytes.
// A start item clears the line and leaves the halted state entered by "exit";
// bytes received while halted give no output. The LED levels and the halted
// flag sent with each byte are those after its item.
module serial_line_command_interpreter #(
  parameter int LINE_BYTES = 64
) (
  input logic        clk,
  input logic        rst_n,
  slci_in_if.sink    in_ch,
  slci_out_if.source out_ch
);
  import slci_pkg::*;

  item_t push_item, pop_item;
  logic  push_valid, push_ready, pop_valid, pop_ready;

  slci_front u_front (
    .in_ch      (in_ch),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  slci_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  slci_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

>>> verif/slci_test_pkg.sv
// ----------------------------------------------------------------------------
// slci_test_pkg: action codes and command words for the interpreter bench
// Shared by the reply checker and the stimulus of the test top.
// ----------------------------------------------------------------------------
package slci_test_pkg;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  localparam int NUM_WORDS = 9;
  localparam int EXIT_WORD = 0;

  function automatic string word_text(int w);
    string s;
    case (w)
      0:       s = "exit";
      1:       s = "turn on red";
      2:       s = "turn on blue";
      3:       s = "turn on green";
      4:       s = "turn off red";
      5:       s = "turn off blue";
      6:       s = "turn off green";
      7:       s = "turn on all";
      default: s = "turn off all";
    endcase
    return s;
  endfunction

endpackage

>>> verif/slci_reply_checker.sv
// ----------------------------------------------------------------------------
// slci_reply_checker: predicts and checks the transmit bytes of the interpreter
// Tracks the edited line, LED levels and halt flag from accepted input items,
// queues the expected transmit bytes and compares every accepted output item.
// ----------------------------------------------------------------------------
module slci_reply_checker #(
  parameter int LINE_BYTES = 64
) (
  input  logic clk,
  input  logic rst_n,
  slci_in_if   in_mon,
  slci_out_if  out_mon,
  output int   errors,
  output int   awaiting,
  output int   bytes_checked,
  output int   lines_done
);
  import slci_pkg::*;
  import slci_test_pkg::*;

  localparam led_t LED_NONE  = 3'b000;
  localparam led_t LED_RED   = 3'b001;
  localparam led_t LED_GREEN = 3'b010;
  localparam led_t LED_BLUE  = 3'b100;
  localparam led_t LED_ALL   = 3'b111;

  localparam led_t WORD_SET [NUM_WORDS] = '{
    LED_NONE, LED_RED, LED_BLUE, LED_GREEN, LED_NONE, LED_NONE, LED_NONE, LED_ALL, LED_NONE
  };
  localparam led_t WORD_CLR [NUM_WORDS] = '{
    LED_NONE, LED_NONE, LED_NONE, LED_NONE, LED_RED, LED_BLUE, LED_GREEN, LED_NONE, LED_ALL
  };

  typedef enum {VERDICT_LEDS, VERDICT_EXIT, VERDICT_UNKNOWN} line_verdict_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       red_on;
    logic       green_on;
    logic       blue_on;
    logic       exited;
    logic       last;
  } tx_beat_t;

  logic [7:0] line_chars [LINE_BYTES-1];
  int         line_len;
  led_t       leds;
  logic       halted;
  tx_beat_t   pending_tx [$];

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic bit line_equals(input string word);
    if (word.len() != line_len) begin
      return 1'b0;
    end
    for (int i = 0; i < line_len; i++) begin
      if (line_chars[i] != word[i]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic line_verdict_t interpret_line();
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (line_equals(word_text(w))) begin
        if (w == EXIT_WORD) begin
          return VERDICT_EXIT;
        end
        leds = (leds & ~WORD_CLR[w]) | WORD_SET[w];
        return VERDICT_LEDS;
      end
    end
    return VERDICT_UNKNOWN;
  endfunction

  task automatic predict_reply(input logic act, input logic [7:0] data);
    logic [7:0]    reply [$];
    line_verdict_t verdict;
    string         unk;
    unk = "unknown command";
    if (act == ACT_START) begin
      halted   = 1'b0;
      line_len = 0;
      reply.push_back(CH_GT);
      reply.push_back(CH_SP);
    end else if (halted) begin
      // drop: halted until the next start
    end else if (data == CH_BS || data == CH_DEL) begin
      if (line_len > 0) begin
        line_len--;
        reply.push_back(CH_BS);
        reply.push_back(CH_SP);
        reply.push_back(CH_BS);
      end
    end else if (data == CH_CR || data == CH_LF) begin
      reply.push_back(CH_CR);
      reply.push_back(CH_LF);
      if (line_len == 0) begin
        reply.push_back(CH_GT);
        reply.push_back(CH_SP);
      end else begin
        verdict  = interpret_line();
        line_len = 0;
        lines_done++;
        if (verdict == VERDICT_EXIT) begin
          halted = 1'b1;
        end else begin
          if (verdict == VERDICT_UNKNOWN) begin
            for (int k = 0; k < unk.len(); k++) begin
              reply.push_back(unk[k]);
            end
            reply.push_back(CH_CR);
            reply.push_back(CH_LF);
          end
          reply.push_back(CH_GT);
          reply.push_back(CH_SP);
        end
      end
    end else if (line_len < LINE_BYTES - 1) begin
      line_chars[line_len] = data;
      line_len++;
      reply.push_back(data);
    end
    foreach (reply[i]) begin
      pending_tx.push_back('{tx_byte: reply[i], red_on: leds[0], green_on: leds[1],
                             blue_on: leds[2], exited: halted,
                             last: (i == reply.size() - 1)});
    end
  endtask

  always @(posedge clk) begin : watch
    tx_beat_t got;
    tx_beat_t want;
    if (!rst_n) begin
      pending_tx.delete();
      line_len = 0;
      leds     = LED_NONE;
      halted   = 1'b1;
    end else begin
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        predict_reply(in_mon.action, in_mon.rx_byte);
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got = '{out_mon.tx_byte, out_mon.red_on, out_mon.green_on, out_mon.blue_on,
                out_mon.exited, out_mon.last};
        if (pending_tx.size() == 0) begin
          report_mismatch($sformatf("byte %02h sent with nothing expected", got.tx_byte));
        end else begin
          want = pending_tx.pop_front();
          if (got.tx_byte !== want.tx_byte) begin
            report_mismatch($sformatf("result %0d tx_byte %02h, expected %02h",
                                      bytes_checked, got.tx_byte, want.tx_byte));
          end
          if (got.red_on !== want.red_on) begin
            report_mismatch($sformatf("result %0d red_on %b, expected %b",
                                      bytes_checked, got.red_on, want.red_on));
          end
          if (got.green_on !== want.green_on) begin
            report_mismatch($sformatf("result %0d green_on %b, expected %b",
                                      bytes_checked, got.green_on, want.green_on));
          end
          if (got.blue_on !== want.blue_on) begin
            report_mismatch($sformatf("result %0d blue_on %b, expected %b",
                                      bytes_checked, got.blue_on, want.blue_on));
          end
          if (got.exited !== want.exited) begin
            report_mismatch($sformatf("result %0d exited %b, expected %b",
                                      bytes_checked, got.exited, want.exited));
          end
          if (got.last !== want.last) begin
            report_mismatch($sformatf("result %0d last %b, expected %b",
                                      bytes_checked, got.last, want.last));
          end
        end
        bytes_checked++;
      end
    end
    awaiting <= pending_tx.size();
  end

endmodule

>>> verif/serial_line_command_interpreter_test.sv
// ----------------------------------------------------------------------------
// serial_line_command_interpreter_test: top of the command interpreter bench
// Drives directed edits and random command lines with idle bursts on both
// channels, a long output stall over a full line, and gives the verdict.
// ----------------------------------------------------------------------------
module serial_line_command_interpreter_test;
  import slci_pkg::*;
  import slci_test_pkg::*;

  localparam int LINE_BYTES   = 64;
  localparam int ITEM_TARGET  = 130;
  localparam int CALM_ITEMS   = 25;
  localparam int LONG_HOLD    = 250;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   gaps_on;
  bit   calm;
  bit   hold_req;
  int   items_sent;
  int   cmd_cursor;
  int   cycles;
  int   errors;
  int   awaiting;
  int   bytes_checked;
  int   lines_done;

  slci_in_if  in_ch ();
  slci_out_if out_ch ();

  serial_line_command_interpreter #(.LINE_BYTES(LINE_BYTES)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  slci_reply_checker #(.LINE_BYTES(LINE_BYTES)) u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .errors        (errors),
    .awaiting      (awaiting),
    .bytes_checked (bytes_checked),
    .lines_done    (lines_done)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycles, awaiting);
      $display("** serial_line_command_interpreter: FAILED **");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold on request, none when calm
  initial begin : receiver
    bit hold_served;
    hold_served  = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  function automatic logic [7:0] pick_eol();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  function automatic logic [7:0] pick_erase();
    return $urandom_range(0, 1) ? CH_BS : CH_DEL;
  endfunction

  task automatic hold_input(input int n);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic key_in(input logic act, input logic [7:0] data);
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.rx_byte <= data;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      hold_input($urandom_range(1, 11));
    end
  endtask

  task automatic type_line(input string text, input bit slip);
    int slip_at;
    slip_at = slip ? $urandom_range(0, text.len()) : -1;
    for (int i = 0; i <= text.len(); i++) begin
      if (i == slip_at) begin
        key_in(ACT_BYTE, 8'($urandom_range(8'h21, 8'h7E)));
        key_in(ACT_BYTE, pick_erase());
      end
      if (i < text.len()) begin
        key_in(ACT_BYTE, text[i]);
      end
    end
    key_in(ACT_BYTE, pick_eol());
    if (text == word_text(EXIT_WORD)) begin
      repeat ($urandom_range(0, 2)) key_in(ACT_BYTE, 8'($urandom_range(0, 255)));
      key_in(ACT_START, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic line_sequence();
    string word;
    int    n;
    case ($urandom_range(0, 9))
      0: key_in(ACT_START, 8'($urandom_range(0, 255)));
      1, 2, 3, 4: begin
        type_line(word_text(cmd_cursor % NUM_WORDS), $urandom_range(0, 2) == 0);
        cmd_cursor++;
      end
      5: begin
        word = word_text($urandom_range(0, NUM_WORDS - 1));
        case ($urandom_range(0, 3))
          0: word = word.substr(0, word.len() - 2);
          1: word = {word, "x"};
          2: word.putc($urandom_range(0, word.len() - 1), 8'($urandom_range("a", "z")));
          default: word = {" ", word};
        endcase
        type_line(word, 1'b0);
      end
      6, 7: begin
        repeat ($urandom_range(0, 8)) key_in(ACT_BYTE, 8'($urandom_range(0, 255)));
        key_in(ACT_BYTE, pick_eol());
      end
      8: begin
        n = $urandom_range(1, 4);
        repeat (n) key_in(ACT_BYTE, 8'($urandom_range(8'h21, 8'h7E)));
        repeat (n + $urandom_range(1, 3)) key_in(ACT_BYTE, pick_erase());
        key_in(ACT_BYTE, pick_eol());
      end
      default: begin
        repeat ($urandom_range(1, 5)) key_in(ACT_BYTE, 8'($urandom_range(8'h21, 8'h7E)));
        key_in(ACT_START, 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin : stimulus
    int calm_from;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_START;
    in_ch.rx_byte = 8'h00;
    gaps_on       = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // halted after reset, then empty-line editing and line ends
    key_in(ACT_BYTE, 8'hFF);
    key_in(ACT_BYTE, CH_CR);
    key_in(ACT_START, 8'h00);
    key_in(ACT_BYTE, CH_BS);
    key_in(ACT_BYTE, CH_DEL);
    key_in(ACT_BYTE, CH_CR);
    key_in(ACT_BYTE, CH_LF);
    key_in(ACT_BYTE, "a");
    key_in(ACT_BYTE, 8'h00);
    key_in(ACT_BYTE, 8'hFF);
    key_in(ACT_BYTE, CH_LF);
    key_in(ACT_BYTE, "a");
    key_in(ACT_BYTE, "b");
    key_in(ACT_BYTE, CH_DEL);
    key_in(ACT_BYTE, CH_BS);
    key_in(ACT_BYTE, CH_BS);
    key_in(ACT_BYTE, "z");
    key_in(ACT_START, 8'hFF);
    key_in(ACT_BYTE, CH_CR);
    type_line(word_text(EXIT_WORD), 1'b0);

    while (items_sent < ITEM_TARGET / 4) begin
      line_sequence();
    end

    // overfill the line while the output is held off
    hold_req = 1'b1;
    gaps_on  = 1'b0;
    key_in(ACT_START, 8'($urandom_range(0, 255)));
    repeat (LINE_BYTES + 2) key_in(ACT_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
    key_in(ACT_BYTE, CH_DEL);
    key_in(ACT_BYTE, CH_CR);
    hold_input(1);
    while (awaiting != 0) @(negedge clk);
    gaps_on = 1'b1;

    while (items_sent < ITEM_TARGET - CALM_ITEMS) begin
      line_sequence();
    end

    calm      = 1'b1;
    gaps_on   = 1'b0;
    calm_from = items_sent;
    while (items_sent < calm_from + CALM_ITEMS) begin
      line_sequence();
    end
    hold_input(1);
    while (awaiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d input items: directed edits, random command lines, noise,",
             items_sent);
    $display("and a full line under a long output stall; %0d bytes over %0d lines",
             bytes_checked, lines_done);
    if (errors == 0 && awaiting == 0) begin
      $display("** serial_line_command_interpreter: PASSED **");
    end else begin
      $display("** serial_line_command_interpreter: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/slci_pkg.sv
sv/slci_if.sv
sv/slci_front.sv
sv/slci_fifo.sv
sv/slci_back.sv
sv/serial_line_command_interpreter.sv
verif/slci_test_pkg.sv
verif/slci_reply_checker.sv
verif/serial_line_command_interpreter_test.sv
